[hdl/hab_pkg.sv]
// Shared constants, codes and types of the histogram accumulator.
// No dependencies; imported by hab_binner and the accumulator core.
`default_nettype none

package hab_pkg;

	localparam int NUM_BINS = 1024;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int NB_W     = BIN_W + 1;
	localparam int Q_W      = BIN_W + 2;
	localparam int DIV_STEPS = Q_W;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	localparam logic [31:0] CNT_MAX = 32'h7fff_ffff;

	localparam logic [1:0] CMD_BIN   = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] CFG_BIN_START = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_BIN_SIZE  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_NUM_BINS  = 2'd2;

	typedef struct packed {
		logic             done;
		logic [BIN_W-1:0] bin;
	} hab_bin_t;

endpackage

`default_nettype wire

[hdl/hab_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module hab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/hab_binner.sv]
// Bin index unit: restoring divide of (sample - start) by bin size, one
// quotient bit per cycle, then clamp to the bins in use. Uses hab_pkg.
`default_nettype none

module hab_binner import hab_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] sample_value,
	input  wire logic signed [31:0] bin_start,
	input  wire logic [30:0]        bin_size,
	input  wire logic [NB_W-1:0]    nb,
	output hab_bin_t                res
);

	localparam int DW = 31 + Q_W - 1;

	logic signed [32:0] diff;
	logic [30:0]        size_eff;
	logic [DW-1:0]      d_q;
	logic [31:0]        rem_q;
	logic [Q_W-1:0]     q_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic               ge;
	logic               last;
	logic               sat;
	logic [NB_W-1:0]    nb_m1;

	assign diff     = {sample_value[31], sample_value} - {bin_start[31], bin_start};
	assign size_eff = (bin_size == '0) ? 31'd1 : bin_size;
	assign ge       = {{(DW-32){1'b0}}, rem_q} >= d_q;
	assign last     = step_q == STEP_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q & last;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= diff[32] ? 32'd0 : diff[31:0];
			d_q   <= {size_eff, {(Q_W-1){1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - d_q[31:0];
			end
			q_q <= {q_q[Q_W-2:0], ge};
			d_q <= d_q >> 1;
		end
	end

	// quotient of 2^NB_W or more saturates regardless of the low bits
	assign nb_m1    = nb - 1'b1;
	assign sat      = q_q[Q_W-1] | (q_q[NB_W-1:0] >= nb);
	assign res.done = done_q;
	assign res.bin  = sat ? nb_m1[BIN_W-1:0] : q_q[BIN_W-1:0];

endmodule

`default_nettype wire

[hdl/histogram_accumulator_with_peak_and_span_core.sv]
// Histogram accumulator: bins Q16.16 samples, sets or clears bin counts, and
// tracks the peak bin and the span of used bins. One word in, one word out.
// Counts live in one NUM_BINS x 32 RAM. After reset, and for each clear
// command, a sweep writes zero to every entry, one per cycle, with
// in_ready low; config writes are taken throughout. A sample passes the bin
// divider (one quotient bit per cycle), then the RAM read and modify, then
// emit; an in-range set skips the divider; a clear runs the sweep before
// emit; a refused word goes straight to emit. One word is in flight at a
// time; a new word is taken while the last result waits.
// Uses hab_pkg, hab_binner and hab_ram.
`default_nettype none

module histogram_accumulator_with_peak_and_span_core import hab_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          cmd,
	input  wire logic signed [31:0]  sample_value,
	input  wire logic [BIN_W-1:0]    bin_index,
	input  wire logic signed [31:0]  bin_count,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     ok,
	output logic [BIN_W-1:0]         bin_used,
	output logic signed [31:0]       new_count,
	output logic signed [31:0]       peak_count,
	output logic [BIN_W-1:0]         peak_bin,
	output logic signed [NB_W-1:0]   first_used,
	output logic signed [NB_W-1:0]   last_used,
	input  wire logic                cfg_we,
	input  wire logic [CFG_AW-1:0]   cfg_addr,
	input  wire logic [31:0]         cfg_wdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	localparam logic signed [NB_W-1:0] SPAN_NONE = '1;

	logic [2:0]               state_q;
	logic signed [31:0]       bin_start_q;
	logic [30:0]              bin_size_q;
	logic [NB_W-1:0]          num_bins_q;
	logic [NB_W-1:0]          nb_eff;
	logic                     in_acc;
	logic                     out_free;

	logic [1:0]               cmd_q;
	logic [BIN_W-1:0]         bin_q;
	logic signed [31:0]       wval_q;
	logic [BIN_W-1:0]         clr_addr_q;
	logic                     clr_emit_q;

	logic signed [31:0]       peak_q;
	logic [BIN_W-1:0]         peak_pos_q;
	logic signed [NB_W-1:0]   low_q;
	logic signed [NB_W-1:0]   high_q;

	logic                     res_ok_q;
	logic [BIN_W-1:0]         res_bin_q;
	logic signed [31:0]       res_cnt_q;
	logic                     out_valid_q;

	hab_bin_t                 bin_res;
	logic                     ram_we;
	logic [BIN_W-1:0]         ram_waddr;
	logic [31:0]              ram_wdata;
	logic [31:0]              ram_rdata;

	logic signed [31:0]       cnt_new;
	logic                     widen;
	logic signed [NB_W-1:0]   b_ext;

	assign nb_eff = (num_bins_q == '0) ? NB_W'(1) :
			(num_bins_q > NB_W'(NUM_BINS)) ? NB_W'(NUM_BINS) : num_bins_q;

	assign in_ready = state_q == ST_IDLE;
	assign in_acc   = in_valid & in_ready;
	assign out_free = !out_valid_q || out_ready;

	hab_binner u_binner (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_acc && cmd == CMD_BIN),
		.sample_value (sample_value),
		.bin_start    (bin_start_q),
		.bin_size     (bin_size_q),
		.nb           (nb_eff),
		.res          (bin_res)
	);

	hab_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (bin_q),
		.rdata (ram_rdata)
	);

	// new count of the bin under modify
	assign cnt_new = (cmd_q == CMD_BIN) ?
			((ram_rdata == CNT_MAX) ? $signed(ram_rdata) : $signed(ram_rdata + 32'd1)) :
			wval_q;
	assign widen = (cmd_q == CMD_BIN) || (cnt_new != 32'sd0);
	assign b_ext = $signed({1'b0, bin_q});

	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_MOD);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : bin_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? 32'd0 : cnt_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_start_q <= '0;
			bin_size_q  <= 31'd65536;
			num_bins_q  <= NB_W'(NUM_BINS);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BIN_START: bin_start_q <= cfg_wdata;
				CFG_BIN_SIZE:  bin_size_q  <= cfg_wdata[30:0];
				CFG_NUM_BINS:  num_bins_q  <= cfg_wdata[NB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			clr_emit_q  <= 1'b0;
			peak_q      <= '0;
			peak_pos_q  <= '0;
			low_q       <= SPAN_NONE;
			high_q      <= SPAN_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= clr_emit_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							CMD_BIN: state_q <= ST_DIV;
							CMD_SET: state_q <= ({1'b0, bin_index} < nb_eff) ? ST_READ : ST_EMIT;
							CMD_CLEAR: begin
								peak_q     <= '0;
								peak_pos_q <= '0;
								low_q      <= SPAN_NONE;
								high_q     <= SPAN_NONE;
								clr_emit_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_DIV: begin
					if (bin_res.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MOD;
				ST_MOD: begin
					if (cnt_new > peak_q) begin
						peak_q     <= cnt_new;
						peak_pos_q <= bin_q;
					end
					if (widen) begin
						if (low_q[NB_W-1] || b_ext < low_q) begin
							low_q <= b_ext;
						end
						if (high_q[NB_W-1] || b_ext > high_q) begin
							high_q <= b_ext;
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q     <= cmd;
			wval_q    <= bin_count;
			bin_q     <= bin_index;
			res_ok_q  <= (cmd == CMD_CLEAR);
			res_bin_q <= (cmd == CMD_SET) ? bin_index : '0;
			res_cnt_q <= '0;
		end else if (state_q == ST_DIV && bin_res.done) begin
			bin_q <= bin_res.bin;
		end else if (state_q == ST_MOD) begin
			res_ok_q  <= 1'b1;
			res_bin_q <= bin_q;
			res_cnt_q <= cnt_new;
		end
		if (state_q == ST_EMIT && out_free) begin
			ok         <= res_ok_q;
			bin_used   <= res_bin_q;
			new_count  <= res_cnt_q;
			peak_count <= peak_q;
			peak_bin   <= peak_pos_q;
			first_used <= low_q;
			last_used  <= high_q;
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		bin_res.done |-> (state_q == ST_DIV))
		else $error("bin unit finished outside of divide state");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(low_q[NB_W-1] == high_q[NB_W-1]) && (low_q[NB_W-1] || low_q <= high_q))
		else $error("span ends inconsistent");

	a_peak_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_q[31])
		else $error("peak count went negative");

	a_mod_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> ($past(state_q) == ST_READ))
		else $error("modify without a preceding read");

endmodule

`default_nettype wire
